// ===== rtl/abkf_pkg.sv =====
// Shared types, constants and saturation helpers for the angle/bias Kalman filter.
`timescale 1ns / 1ps

package abkf_pkg;

   // Signed working width for sums before saturation
   localparam int WideWidth = 58;
   typedef logic signed [WideWidth-1:0] wide_type;

   localparam logic [31:0] ANGLE_NOISE_RESET = 32'd3435974;
   localparam logic [31:0] BIAS_NOISE_RESET  = 32'd8589935;
   localparam logic [31:0] MEAS_NOISE_RESET  = 32'd2147483648;
   localparam logic [31:0] TIME_STEP_RESET   = 32'd4294967;
   localparam logic signed [47:0] ONE_Q40    = 48'sh0100_0000_0000;
   localparam logic signed [47:0] MAX48      = 48'sh7FFF_FFFF_FFFF;

   localparam logic [7:0] REG_ANGLE_NOISE = 8'd0;
   localparam logic [7:0] REG_BIAS_NOISE  = 8'd1;
   localparam logic [7:0] REG_MEAS_NOISE  = 8'd2;
   localparam logic [7:0] REG_TIME_STEP   = 8'd3;

   localparam logic [6:0] MUL_LAST = 7'd2;
   localparam logic [6:0] DIV_LAST = 7'd87;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL,
      ST_ROUND,
      ST_WB,
      ST_PREP,
      ST_DIV_LOAD,
      ST_DIV,
      ST_DIV_END,
      ST_FINISH
   } state_type;

   typedef enum logic [3:0] {
      OP_PRED_ANGLE,
      OP_PRED_P00,
      OP_PRED_P01,
      OP_PRED_P11,
      OP_CORR_P10,
      OP_CORR_P11,
      OP_CORR_P00,
      OP_CORR_P01,
      OP_CORR_ANGLE,
      OP_CORR_BIAS
   } op_type;

   function automatic logic signed [31:0] sat32(input wide_type x);
      if (x[WideWidth-1:31] == {(WideWidth-31){x[WideWidth-1]}}) begin
         return x[31:0];
      end
      return x[WideWidth-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
   endfunction

   function automatic logic signed [47:0] sat48(input wide_type x);
      if (x[WideWidth-1:47] == {(WideWidth-47){x[WideWidth-1]}}) begin
         return x[47:0];
      end
      return x[WideWidth-1] ? 48'sh8000_0000_0000 : MAX48;
   endfunction

   function automatic op_type next_op(input op_type op);
      unique case (op)
         OP_PRED_ANGLE: return OP_PRED_P00;
         OP_PRED_P00:   return OP_PRED_P01;
         OP_PRED_P01:   return OP_PRED_P11;
         OP_PRED_P11:   return OP_CORR_P10;
         OP_CORR_P10:   return OP_CORR_P11;
         OP_CORR_P11:   return OP_CORR_P00;
         OP_CORR_P00:   return OP_CORR_P01;
         OP_CORR_P01:   return OP_CORR_ANGLE;
         OP_CORR_ANGLE: return OP_CORR_BIAS;
         default:       return OP_PRED_ANGLE;
      endcase
   endfunction

endpackage

// ===== rtl/angle_bias_kalman_filter_unit.sv =====
// Two-state angle/gyro-bias Kalman filter with a shared multiplier and serial divider.
`timescale 1ns / 1ps

// For each sample, ten products run through one 52x16 multiplier in three passes each
// (with operand load, rounding and write-back states around them), and the two gains
// come from a restoring divider that retires one quotient bit per cycle over 88 bits.
// The block takes no new sample while one is in progress; a finished result may wait
// in the output register while the next sample is accepted. Registers on the csr port
// are written whenever csr_valid is high and should only change while the filter is idle.
module angle_bias_kalman_filter_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [23:0] req_measured_angle,
   input  logic signed [27:0] req_measured_rate,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_angle_estimate,
   output logic signed [31:0] rsp_unbiased_rate,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   abkf_pkg::state_type state_ff, state_in;
   abkf_pkg::op_type    op_ff, op_in;

   logic [31:0] q_angle_ff, q_bias_ff, r_meas_ff, dt_ff;

   logic signed [31:0] angle_ff, angle_in, bias_ff, bias_in;
   logic signed [47:0] p00_ff, p00_in, p01_ff, p01_in, p10_ff, p10_in, p11_ff, p11_in;

   logic signed [23:0] m_angle_ff, m_angle_in;
   logic signed [27:0] m_rate_ff, m_rate_in;
   logic signed [31:0] err_ff, err_in;
   logic signed [47:0] e_ff, e_in, k0_ff, k0_in, k1_ff, k1_in;

   logic [6:0]         cnt_ff, cnt_in;
   logic [51:0]        mul_a_ff, mul_a_in;
   logic [47:0]        mul_b_ff, mul_b_in;
   logic               mul_neg_ff, mul_neg_in, mul_q40_ff, mul_q40_in;
   logic [99:0]        acc_ff, acc_in;
   abkf_pkg::wide_type mul_res_ff, mul_res_in;

   logic [47:0]        div_num_ff, div_num_in, div_den_ff, div_den_in;
   logic [48:0]        div_rem_ff, div_rem_in, div_quo_ff, div_quo_in;
   logic               div_over_ff, div_over_in, div_neg_ff, div_neg_in;
   logic               div_second_ff, div_second_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_angle_ff, rsp_angle_in, rsp_rate_ff, rsp_rate_in;

   logic               finish_go;

   assign finish_go = !(rsp_valid_ff && !rsp_ready);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         abkf_pkg::ST_IDLE:     if (req_valid) state_in = abkf_pkg::ST_LOAD;
         abkf_pkg::ST_LOAD:     state_in = abkf_pkg::ST_MUL;
         abkf_pkg::ST_MUL:      if (cnt_ff == abkf_pkg::MUL_LAST) state_in = abkf_pkg::ST_ROUND;
         abkf_pkg::ST_ROUND:    state_in = abkf_pkg::ST_WB;
         abkf_pkg::ST_WB: begin
            priority if (op_ff == abkf_pkg::OP_PRED_P11) state_in = abkf_pkg::ST_PREP;
            else if (op_ff == abkf_pkg::OP_CORR_BIAS) state_in = abkf_pkg::ST_FINISH;
            else state_in = abkf_pkg::ST_LOAD;
         end
         abkf_pkg::ST_PREP:     state_in = abkf_pkg::ST_DIV_LOAD;
         abkf_pkg::ST_DIV_LOAD: state_in = abkf_pkg::ST_DIV;
         abkf_pkg::ST_DIV:      if (cnt_ff == abkf_pkg::DIV_LAST) state_in = abkf_pkg::ST_DIV_END;
         abkf_pkg::ST_DIV_END:
            state_in = div_second_ff ? abkf_pkg::ST_LOAD : abkf_pkg::ST_DIV_LOAD;
         abkf_pkg::ST_FINISH:   if (finish_go) state_in = abkf_pkg::ST_IDLE;
         default:               state_in = abkf_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready          = (state_ff == abkf_pkg::ST_IDLE);
      csr_ready          = 1'b1;
      rsp_valid          = rsp_valid_ff;
      rsp_angle_estimate = rsp_angle_ff;
      rsp_unbiased_rate  = rsp_rate_ff;
   end

   // datapath
   always_comb begin
      logic signed [31:0] u32;
      abkf_pkg::wide_type a_w, b_w, a_mag, b_mag, rnd_w, mag_w, e_w;
      logic [67:0]        pp;
      logic [99:0]        rsum;
      logic [55:0]        rmag;
      logic [48:0]        rem_sh, quo_sh;
      logic               ge;
      logic signed [47:0] k_val;

      angle_in      = angle_ff;
      bias_in       = bias_ff;
      p00_in        = p00_ff;
      p01_in        = p01_ff;
      p10_in        = p10_ff;
      p11_in        = p11_ff;
      m_angle_in    = m_angle_ff;
      m_rate_in     = m_rate_ff;
      err_in        = err_ff;
      e_in          = e_ff;
      k0_in         = k0_ff;
      k1_in         = k1_ff;
      op_in         = op_ff;
      cnt_in        = cnt_ff;
      mul_a_in      = mul_a_ff;
      mul_b_in      = mul_b_ff;
      mul_neg_in    = mul_neg_ff;
      mul_q40_in    = mul_q40_ff;
      acc_in        = acc_ff;
      mul_res_in    = mul_res_ff;
      div_num_in    = div_num_ff;
      div_den_in    = div_den_ff;
      div_rem_in    = div_rem_ff;
      div_quo_in    = div_quo_ff;
      div_over_in   = div_over_ff;
      div_neg_in    = div_neg_ff;
      div_second_in = div_second_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_angle_in  = rsp_angle_ff;
      rsp_rate_in   = rsp_rate_ff;

      u32 = abkf_pkg::sat32(abkf_pkg::wide_type'(m_rate_ff) - abkf_pkg::wide_type'(bias_ff));

      // operand selection for the shared multiplier
      a_w = abkf_pkg::wide_type'(k0_ff);
      b_w = abkf_pkg::wide_type'({26'b0, dt_ff});
      unique case (op_ff)
         abkf_pkg::OP_PRED_ANGLE: a_w = abkf_pkg::wide_type'(u32);
         abkf_pkg::OP_PRED_P00:
            a_w = abkf_pkg::wide_type'({18'b0, q_angle_ff, 8'b0})
                - abkf_pkg::wide_type'(p01_ff) - abkf_pkg::wide_type'(p10_ff);
         abkf_pkg::OP_PRED_P01:   a_w = abkf_pkg::wide_type'(p11_ff);
         abkf_pkg::OP_PRED_P11:   a_w = abkf_pkg::wide_type'({18'b0, q_bias_ff, 8'b0});
         abkf_pkg::OP_CORR_P10: begin
            a_w = abkf_pkg::wide_type'(k1_ff);
            b_w = abkf_pkg::wide_type'(p00_ff);
         end
         abkf_pkg::OP_CORR_P11: begin
            a_w = abkf_pkg::wide_type'(k1_ff);
            b_w = abkf_pkg::wide_type'(p01_ff);
         end
         abkf_pkg::OP_CORR_P00:   b_w = abkf_pkg::wide_type'(p00_ff);
         abkf_pkg::OP_CORR_P01:   b_w = abkf_pkg::wide_type'(p01_ff);
         abkf_pkg::OP_CORR_ANGLE: b_w = abkf_pkg::wide_type'(err_ff);
         abkf_pkg::OP_CORR_BIAS: begin
            a_w = abkf_pkg::wide_type'(k1_ff);
            b_w = abkf_pkg::wide_type'(err_ff);
         end
         default: a_w = abkf_pkg::wide_type'(k0_ff);
      endcase
      a_mag = a_w[abkf_pkg::WideWidth-1] ? -a_w : a_w;
      b_mag = b_w[abkf_pkg::WideWidth-1] ? -b_w : b_w;

      pp = mul_a_ff * mul_b_ff[47:32];

      rsum = mul_q40_ff ? (acc_ff + (100'd1 << 39)) : (acc_ff + (100'd1 << 31));
      rmag = mul_q40_ff ? rsum[95:40] : rsum[87:32];
      mag_w = abkf_pkg::wide_type'({2'b0, rmag});
      rnd_w = mul_neg_ff ? -mag_w : mag_w;

      e_w = abkf_pkg::wide_type'(p00_ff) + abkf_pkg::wide_type'({18'b0, r_meas_ff, 8'b0});

      rem_sh = {div_rem_ff[47:0], div_num_ff[47]};
      ge     = (rem_sh >= {1'b0, div_den_ff});
      quo_sh = {div_quo_ff[47:0], ge};

      k_val = div_over_ff ? abkf_pkg::MAX48 : div_quo_ff[47:0];
      if (div_neg_ff) begin
         k_val = -k_val;
      end
      if (e_ff == 48'sd0) begin
         k_val = 48'sd0;
      end

      unique case (state_ff)
         abkf_pkg::ST_IDLE: begin
            if (req_valid) begin
               m_angle_in = req_measured_angle;
               m_rate_in  = req_measured_rate;
               op_in      = abkf_pkg::OP_PRED_ANGLE;
            end
         end
         abkf_pkg::ST_LOAD: begin
            mul_a_in   = a_mag[51:0];
            mul_b_in   = b_mag[47:0];
            mul_neg_in = a_w[abkf_pkg::WideWidth-1] ^ b_w[abkf_pkg::WideWidth-1];
            mul_q40_in = (op_ff != abkf_pkg::OP_PRED_ANGLE) && (op_ff != abkf_pkg::OP_PRED_P00)
                      && (op_ff != abkf_pkg::OP_PRED_P01) && (op_ff != abkf_pkg::OP_PRED_P11);
            acc_in     = '0;
            cnt_in     = '0;
         end
         abkf_pkg::ST_MUL: begin
            // advance one 16-bit digit of the multiplier, top first
            acc_in   = {acc_ff[83:0], 16'b0} + {32'b0, pp};
            mul_b_in = {mul_b_ff[31:0], 16'b0};
            cnt_in   = cnt_ff + 7'd1;
         end
         abkf_pkg::ST_ROUND: mul_res_in = rnd_w;
         abkf_pkg::ST_WB: begin
            op_in = abkf_pkg::next_op(op_ff);
            unique case (op_ff)
               abkf_pkg::OP_PRED_ANGLE, abkf_pkg::OP_CORR_ANGLE:
                  angle_in = abkf_pkg::sat32(abkf_pkg::wide_type'(angle_ff) + mul_res_ff);
               abkf_pkg::OP_CORR_BIAS:
                  bias_in = abkf_pkg::sat32(abkf_pkg::wide_type'(bias_ff) + mul_res_ff);
               abkf_pkg::OP_PRED_P00:
                  p00_in = abkf_pkg::sat48(abkf_pkg::wide_type'(p00_ff) + mul_res_ff);
               abkf_pkg::OP_PRED_P01: begin
                  p01_in = abkf_pkg::sat48(abkf_pkg::wide_type'(p01_ff) - mul_res_ff);
                  p10_in = abkf_pkg::sat48(abkf_pkg::wide_type'(p10_ff) - mul_res_ff);
               end
               abkf_pkg::OP_PRED_P11:
                  p11_in = abkf_pkg::sat48(abkf_pkg::wide_type'(p11_ff) + mul_res_ff);
               abkf_pkg::OP_CORR_P10:
                  p10_in = abkf_pkg::sat48(abkf_pkg::wide_type'(p10_ff) - mul_res_ff);
               abkf_pkg::OP_CORR_P11:
                  p11_in = abkf_pkg::sat48(abkf_pkg::wide_type'(p11_ff) - mul_res_ff);
               abkf_pkg::OP_CORR_P00:
                  p00_in = abkf_pkg::sat48(abkf_pkg::wide_type'(p00_ff) - mul_res_ff);
               abkf_pkg::OP_CORR_P01:
                  p01_in = abkf_pkg::sat48(abkf_pkg::wide_type'(p01_ff) - mul_res_ff);
               default: angle_in = angle_ff;
            endcase
         end
         abkf_pkg::ST_PREP: begin
            err_in = abkf_pkg::sat32(abkf_pkg::wide_type'(m_angle_ff)
                                   - abkf_pkg::wide_type'(angle_ff));
            e_in          = abkf_pkg::sat48(e_w);
            div_second_in = 1'b0;
         end
         abkf_pkg::ST_DIV_LOAD: begin
            if (div_second_ff) begin
               div_num_in = p10_ff[47] ? 48'(-p10_ff) : p10_ff;
               div_neg_in = p10_ff[47] ^ e_ff[47];
            end else begin
               div_num_in = p00_ff[47] ? 48'(-p00_ff) : p00_ff;
               div_neg_in = p00_ff[47] ^ e_ff[47];
            end
            div_den_in  = e_ff[47] ? 48'(-e_ff) : e_ff;
            div_rem_in  = '0;
            div_quo_in  = '0;
            div_over_in = 1'b0;
            cnt_in      = '0;
         end
         abkf_pkg::ST_DIV: begin
            // one quotient bit per cycle; the dividend feeds zeros once exhausted
            // a quotient that reaches bit 47 no longer fits the signed gain
            div_num_in  = {div_num_ff[46:0], 1'b0};
            div_rem_in  = ge ? (rem_sh - {1'b0, div_den_ff}) : rem_sh;
            div_quo_in  = quo_sh;
            div_over_in = div_over_ff | quo_sh[48] | quo_sh[47];
            cnt_in      = cnt_ff + 7'd1;
         end
         abkf_pkg::ST_DIV_END: begin
            if (div_second_ff) begin
               k1_in = k_val;
            end else begin
               k0_in = k_val;
            end
            div_second_in = 1'b1;
         end
         abkf_pkg::ST_FINISH: begin
            if (finish_go) begin
               rsp_valid_in = 1'b1;
               rsp_angle_in = angle_ff;
               rsp_rate_in  = u32;
            end
         end
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= abkf_pkg::ST_IDLE;
         op_ff        <= abkf_pkg::OP_PRED_ANGLE;
         rsp_valid_ff <= 1'b0;
         q_angle_ff   <= abkf_pkg::ANGLE_NOISE_RESET;
         q_bias_ff    <= abkf_pkg::BIAS_NOISE_RESET;
         r_meas_ff    <= abkf_pkg::MEAS_NOISE_RESET;
         dt_ff        <= abkf_pkg::TIME_STEP_RESET;
         angle_ff     <= '0;
         bias_ff      <= '0;
         p00_ff       <= abkf_pkg::ONE_Q40;
         p01_ff       <= '0;
         p10_ff       <= '0;
         p11_ff       <= abkf_pkg::ONE_Q40;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
         angle_ff     <= angle_in;
         bias_ff      <= bias_in;
         p00_ff       <= p00_in;
         p01_ff       <= p01_in;
         p10_ff       <= p10_in;
         p11_ff       <= p11_in;
         // drop writes beyond the register list
         if (csr_valid) begin
            if (csr_index == abkf_pkg::REG_ANGLE_NOISE) q_angle_ff <= csr_wdata;
            if (csr_index == abkf_pkg::REG_BIAS_NOISE)  q_bias_ff  <= csr_wdata;
            if (csr_index == abkf_pkg::REG_MEAS_NOISE)  r_meas_ff  <= csr_wdata;
            if (csr_index == abkf_pkg::REG_TIME_STEP)   dt_ff      <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      m_angle_ff    <= m_angle_in;
      m_rate_ff     <= m_rate_in;
      err_ff        <= err_in;
      e_ff          <= e_in;
      k0_ff         <= k0_in;
      k1_ff         <= k1_in;
      cnt_ff        <= cnt_in;
      mul_a_ff      <= mul_a_in;
      mul_b_ff      <= mul_b_in;
      mul_neg_ff    <= mul_neg_in;
      mul_q40_ff    <= mul_q40_in;
      acc_ff        <= acc_in;
      mul_res_ff    <= mul_res_in;
      div_num_ff    <= div_num_in;
      div_den_ff    <= div_den_in;
      div_rem_ff    <= div_rem_in;
      div_quo_ff    <= div_quo_in;
      div_over_ff   <= div_over_in;
      div_neg_ff    <= div_neg_in;
      div_second_ff <= div_second_in;
      rsp_angle_ff  <= rsp_angle_in;
      rsp_rate_ff   <= rsp_rate_in;
   end

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == abkf_pkg::ST_LOAD))
      else $error("sample accepted but sequencer did not start");

   a_mul_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == abkf_pkg::ST_MUL) |-> (cnt_ff <= abkf_pkg::MUL_LAST))
      else $error("multiplier digit count overran");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == abkf_pkg::ST_DIV) |-> (cnt_ff <= abkf_pkg::DIV_LAST))
      else $error("divider bit count overran");

   a_result_posted: assert property (@(posedge clock) disable iff (reset)
      (state_ff == abkf_pkg::ST_FINISH && finish_go) |=> rsp_valid_ff)
      else $error("finished sample did not post a result");

   a_second_gain_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == abkf_pkg::ST_DIV_END && div_second_ff)
      |=> (op_ff == abkf_pkg::OP_CORR_P10))
      else $error("correction did not start after both gains");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the angle/gyro-bias Kalman filter unit.
`timescale 1ns / 1ps

module tb;

   typedef logic signed [127:0] big_type;

   localparam logic [7:0] REG_UNUSED = 8'd200;
   localparam int CycleLimit = 1500000;
   localparam int DrainCycles = 300;
   localparam big_type Max48 = (128'sd1 <<< 47) - 1;
   localparam big_type Min48 = -(128'sd1 <<< 47);

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [23:0] req_measured_angle = '0;
   logic signed [27:0] req_measured_rate = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_angle_estimate;
   logic signed [31:0] rsp_unbiased_rate;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [7:0]         csr_index = '0;
   logic [31:0]        csr_wdata = '0;

   angle_bias_kalman_filter_unit dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // filter model state and registers
   logic [31:0] q_angle, q_bias, r_meas, dt;
   big_type est_angle, est_bias, p_aa, p_ab, p_ba, p_bb;

   logic signed [31:0] angle_queue[$];
   logic signed [31:0] rate_queue[$];
   int  fail_count = 0;
   int  cycle_count = 0;
   bit  calm = 1'b0;

   function automatic big_type sat_q16(big_type x);
      if (x > 128'sd2147483647) return 128'sd2147483647;
      if (x < -128'sd2147483648) return -128'sd2147483648;
      return x;
   endfunction

   function automatic big_type sat_q40(big_type x);
      if (x > Max48) return Max48;
      if (x < Min48) return Min48;
      return x;
   endfunction

   function automatic big_type magnitude(big_type x);
      return x < 0 ? -x : x;
   endfunction

   // round(a * b / 2^32), ties away from zero
   function automatic big_type scale_q32(big_type a, logic [31:0] b);
      big_type m;
      m = (magnitude(a) * big_type'({96'd0, b}) + (128'sd1 <<< 31)) >>> 32;
      return a < 0 ? -m : m;
   endfunction

   function automatic big_type scale_q40(big_type a, big_type b);
      big_type m;
      m = (magnitude(a) * magnitude(b) + (128'sd1 <<< 39)) >>> 40;
      return ((a < 0) != (b < 0)) ? -m : m;
   endfunction

   function automatic big_type gain_q40(big_type n, big_type d);
      big_type q;
      if (d == 0) return 0;
      q = (magnitude(n) <<< 40) / magnitude(d);
      if (q > Max48) q = Max48;
      return ((n < 0) != (d < 0)) ? -q : q;
   endfunction

   task automatic reset_model();
      q_angle = abkf_pkg::ANGLE_NOISE_RESET;
      q_bias = abkf_pkg::BIAS_NOISE_RESET;
      r_meas = abkf_pkg::MEAS_NOISE_RESET;
      dt = abkf_pkg::TIME_STEP_RESET;
      est_angle = 0;
      est_bias = 0;
      p_aa = big_type'(abkf_pkg::ONE_Q40);
      p_ab = 0;
      p_ba = 0;
      p_bb = big_type'(abkf_pkg::ONE_Q40);
   endtask

   task automatic predict_filter(logic signed [23:0] m_angle, logic signed [27:0] m_rate);
      big_type u, err, e, k0, k1, p00, p01, p10, p11;
      u = sat_q16(big_type'(m_rate) - est_bias);
      est_angle = sat_q16(est_angle + scale_q32(u, dt));
      p00 = p_aa; p01 = p_ab; p10 = p_ba; p11 = p_bb;
      p_aa = sat_q40(p00 + scale_q32((big_type'({96'd0, q_angle}) <<< 8) - p01 - p10, dt));
      p_ab = sat_q40(p01 - scale_q32(p11, dt));
      p_ba = sat_q40(p10 - scale_q32(p11, dt));
      p_bb = sat_q40(p11 + scale_q32(big_type'({96'd0, q_bias}) <<< 8, dt));
      err = sat_q16(big_type'(m_angle) - est_angle);
      p00 = p_aa;
      p01 = p_ab;
      e = sat_q40(p00 + (big_type'({96'd0, r_meas}) <<< 8));
      k0 = gain_q40(p00, e);
      k1 = gain_q40(p_ba, e);
      p_aa = sat_q40(p00 - scale_q40(k0, p00));
      p_ab = sat_q40(p01 - scale_q40(k0, p01));
      p_ba = sat_q40(p_ba - scale_q40(k1, p00));
      p_bb = sat_q40(p_bb - scale_q40(k1, p01));
      est_angle = sat_q16(est_angle + scale_q40(k0, err));
      est_bias = sat_q16(est_bias + scale_q40(k1, err));
      u = sat_q16(big_type'(m_rate) - est_bias);
      angle_queue.push_back(est_angle[31:0]);
      rate_queue.push_back(u[31:0]);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         rsp_ready <= calm ? 1'b1 : ($urandom_range(99) >= 11);
      end
   end

   always @(posedge clock) begin
      if (rsp_valid && rsp_ready && !reset) begin
         if (angle_queue.size() == 0) begin
            $display("%0t unexpected beat: expected none, got angle %0d rate %0d", $time,
                     rsp_angle_estimate, rsp_unbiased_rate);
            fail_count++;
         end else begin
            if (rsp_angle_estimate !== angle_queue[0]) begin
               $display("%0t angle_estimate expected %0d got %0d", $time, angle_queue[0],
                        rsp_angle_estimate);
               fail_count++;
            end
            if (rsp_unbiased_rate !== rate_queue[0]) begin
               $display("%0t unbiased_rate expected %0d got %0d", $time, rate_queue[0],
                        rsp_unbiased_rate);
               fail_count++;
            end
            void'(angle_queue.pop_front());
            void'(rate_queue.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic send_sample(logic signed [23:0] m_angle, logic signed [27:0] m_rate);
      bit ready_seen;
      if (!calm && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_measured_angle <= m_angle;
      req_measured_rate <= m_rate;
      // ready seen at the falling edge holds through the next rising edge
      do begin
         @(negedge clock);
         ready_seen = req_ready;
         @(posedge clock);
      end while (!ready_seen);
      predict_filter(m_angle, m_rate);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (angle_queue.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_reg(logic [7:0] index, logic [31:0] value);
      bit ready_seen;
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do begin
         @(negedge clock);
         ready_seen = csr_ready;
         @(posedge clock);
      end while (!ready_seen);
      csr_valid <= 1'b0;
      unique case (index)
         abkf_pkg::REG_ANGLE_NOISE: q_angle = value;
         abkf_pkg::REG_BIAS_NOISE:  q_bias = value;
         abkf_pkg::REG_MEAS_NOISE:  r_meas = value;
         abkf_pkg::REG_TIME_STEP:   dt = value;
         default: ;
      endcase
   endtask

   function automatic logic signed [23:0] rand_angle();
      return 24'(int'($urandom_range(11796480)) - 5898240);
   endfunction

   function automatic logic signed [27:0] rand_rate();
      if ($urandom_range(3) == 0) return 28'(int'($urandom_range(262144000)) - 131072000);
      return 28'(int'($urandom_range(6553600)) - 3276800);
   endfunction

   task automatic test_directed();
      send_sample(24'sd0, 28'sd0);
      send_sample(24'sd5898240, 28'sd131072000);
      send_sample(-24'sd5898240, -28'sd131072000);
      send_sample(24'sd5898240, -28'sd131072000);
      send_sample(-24'sd5898240, 28'sd131072000);
      send_sample(24'sd1, -28'sd1);
      send_sample(-24'sd1, 28'sd1);
      send_sample(24'sh3FFFFF, 28'sh0FFFFFF);
      send_sample(24'shA60000, 28'sh82FFFFF);
      for (int i = 0; i < 8; i++) send_sample(24'sd2949120, 28'sd65536);
   endtask

   task automatic test_random_run(int count);
      calm = 1'b1;
      for (int i = 0; i < count; i++) begin
         if (i == count / 4) calm = 1'b0;
         // hold off until every result is back once
         if (i == count / 2) wait_idle();
         if (i % 200 == 199) begin
            wait_idle();
            write_reg(abkf_pkg::REG_ANGLE_NOISE, $urandom_range(50000000));
            write_reg(abkf_pkg::REG_BIAS_NOISE, $urandom_range(50000000));
            write_reg(abkf_pkg::REG_MEAS_NOISE, $urandom_range(32'hFFFFFFFF, 1));
            write_reg(abkf_pkg::REG_TIME_STEP, $urandom_range(40000000));
         end
         send_sample(rand_angle(), rand_rate());
      end
      calm = 1'b0;
   endtask

   task automatic test_register_extremes();
      logic [31:0] settings[5][4] = '{
         '{32'd0, 32'd0, 32'd1, 32'd0},
         '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF},
         '{32'd0, 32'd0, 32'd1, 32'hFFFFFFFF},
         '{32'hFFFFFFFF, 32'd0, 32'd1, 32'h80000000},
         '{abkf_pkg::ANGLE_NOISE_RESET, abkf_pkg::BIAS_NOISE_RESET,
           abkf_pkg::MEAS_NOISE_RESET, abkf_pkg::TIME_STEP_RESET}};
      for (int s = 0; s < 5; s++) begin
         wait_idle();
         write_reg(abkf_pkg::REG_ANGLE_NOISE, settings[s][0]);
         write_reg(abkf_pkg::REG_BIAS_NOISE, settings[s][1]);
         write_reg(abkf_pkg::REG_MEAS_NOISE, settings[s][2]);
         write_reg(abkf_pkg::REG_TIME_STEP, settings[s][3]);
         write_reg(REG_UNUSED, 32'hFFFFFFFF);
         send_sample(24'sd5898240, 28'sd131072000);
         send_sample(-24'sd5898240, -28'sd131072000);
         for (int i = 0; i < 10; i++) send_sample(rand_angle(), rand_rate());
      end
   endtask

   initial begin
      reset_model();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_run(1240);
      test_register_extremes();
      wait_idle();
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
